@@ rtl/fixed_point_q24_8_alu_top_defines.svh @@
// Assertion macros for the fixed-point ALU checker.
// Used only by the checker file; has no dependencies of its own.
`ifndef FIXED_POINT_Q24_8_ALU_TOP_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_TOP_DEFINES_SVH

// Concurrent property on clk, switched off while rst is high.
`define FPA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fixed-point ALU port check failed");

// Condition that must never be seen at a clock edge.
`define FPA_ASSERT_NEVER(label, clk, rst, cond) \
  `FPA_ASSERT(label, clk, rst, !(cond))

`endif

@@ rtl/fpa_pkg.sv @@
// Shared constants, command codes, pipeline item type and saturation helpers
// for the fixed-point ALU. No dependencies.
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = DATA_W + FRAC_BITS;      // dividend / quotient bits
  localparam int WIDE_W    = DATA_W + FRAC_BITS + 1;  // signed headroom for add/shift
  localparam int MAG_W     = 2 * DATA_W;              // unsigned magnitude width
  localparam int LATENCY   = NUM_W + 3;               // start to done, in cycles

  localparam logic [DATA_W-1:0] RAW_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] RAW_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Command codes
  localparam logic [3:0] CMD_ADD      = 4'd0;
  localparam logic [3:0] CMD_SUB      = 4'd1;
  localparam logic [3:0] CMD_MUL      = 4'd2;
  localparam logic [3:0] CMD_DIV      = 4'd3;
  localparam logic [3:0] CMD_MIN      = 4'd4;
  localparam logic [3:0] CMD_MAX      = 4'd5;
  localparam logic [3:0] CMD_INC      = 4'd6;
  localparam logic [3:0] CMD_DEC      = 4'd7;
  localparam logic [3:0] CMD_TO_INT   = 4'd8;
  localparam logic [3:0] CMD_FROM_INT = 4'd9;

  // One item as it moves down the divider chain
  typedef struct packed {
    logic              valid;
    logic              is_div;  // divide with nonzero divisor
    logic              neg;     // quotient sign
    logic              gt;
    logic              lt;
    logic              eq;
    logic              dz;
    logic              ovf;
    logic [DATA_W-1:0] res;     // final result for every other case
    logic [DATA_W-1:0] den;
    logic [NUM_W-1:0]  num;     // dividend in, quotient out
    logic [DATA_W-1:0] rem;
  } cell_t;

  // Saturate a wide signed value: returns {ovf, result}
  function automatic logic [DATA_W:0] sat_signed(input logic [WIDE_W-1:0] v);
    logic [WIDE_W-DATA_W:0] top;
    begin
      top = v[WIDE_W-1:DATA_W-1];
      if (top == '0 || top == '1) begin
        sat_signed = {1'b0, v[DATA_W-1:0]};
      end else begin
        sat_signed = {1'b1, (v[WIDE_W-1] ? RAW_MIN : RAW_MAX)};
      end
    end
  endfunction

  // Apply sign to a magnitude and saturate: returns {ovf, result}
  function automatic logic [DATA_W:0] sat_mag(input logic [MAG_W-1:0] m, input logic neg);
    logic hi_zero;
    begin
      hi_zero = (m[MAG_W-1:DATA_W] == '0);
      if (neg) begin
        if (hi_zero && (!m[DATA_W-1] || m[DATA_W-2:0] == '0)) begin
          sat_mag = {1'b0, (~m[DATA_W-1:0]) + {{(DATA_W-1){1'b0}}, 1'b1}};
        end else begin
          sat_mag = {1'b1, RAW_MIN};
        end
      end else begin
        if (hi_zero && !m[DATA_W-1]) begin
          sat_mag = {1'b0, m[DATA_W-1:0]};
        end else begin
          sat_mag = {1'b1, RAW_MAX};
        end
      end
    end
  endfunction

endpackage

@@ rtl/fpa_front.sv @@
// Input stages: decode, simple ops, compare flags, multiply, divide setup.
// Depends on fpa_pkg.
module fpa_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [3:0]                  command,
  input  logic signed [31:0]          operand_a,
  input  logic signed [31:0]          operand_b,
  output fpa_pkg::cell_t              dout
);
  import fpa_pkg::*;

  typedef struct packed {
    logic              mul;
    logic              neg;
    logic              gt;
    logic              lt;
    logic              eq;
    logic              dz;
    logic              is_div;
    logic              ovf;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] den;
    logic [NUM_W-1:0]  num;
    logic [MAG_W-1:0]  prod;
  } front_t;

  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [WIDE_W-1:0] wide_a;
  logic [WIDE_W-1:0] wide_b;
  logic [DATA_W:0]   sat;
  front_t            s1_next;
  front_t            s1;
  logic              s1_valid;
  logic [MAG_W-1:0]  prod_rnd;
  logic [DATA_W:0]   mul_sat;
  cell_t             s2_next;
  cell_t             s2;
  logic              s2_valid;

  // Magnitudes and sign-extended operands
  always_comb begin
    mag_a  = operand_a[31] ? (~operand_a) + 32'd1 : operand_a;
    mag_b  = operand_b[31] ? (~operand_b) + 32'd1 : operand_b;
    wide_a = {{(WIDE_W-DATA_W){operand_a[31]}}, operand_a};
    wide_b = {{(WIDE_W-DATA_W){operand_b[31]}}, operand_b};
  end

  // Stage 1: everything but the multiply rounding and the divide loop
  always_comb begin
    s1_next        = '0;
    s1_next.gt     = operand_a > operand_b;
    s1_next.lt     = operand_a < operand_b;
    s1_next.eq     = operand_a == operand_b;
    s1_next.neg    = operand_a[31] ^ operand_b[31];
    s1_next.den    = mag_b;
    s1_next.num    = {mag_a, {FRAC_BITS{1'b0}}};
    s1_next.prod   = MAG_W'(mag_a) * MAG_W'(mag_b);
    s1_next.mul    = (command == CMD_MUL);
    sat            = '0;
    unique case (command)
      CMD_ADD: begin
        sat = sat_signed(wide_a + wide_b);
      end
      CMD_SUB: begin
        sat = sat_signed(wide_a - wide_b);
      end
      CMD_MUL: begin
        sat = '0;
      end
      CMD_DIV: begin
        if (operand_b == '0) begin
          s1_next.dz = 1'b1;
          sat = {1'b1, (operand_a[31] ? RAW_MIN : RAW_MAX)};
        end else begin
          s1_next.is_div = 1'b1;
        end
      end
      CMD_MIN: begin
        sat = {1'b0, (s1_next.lt ? operand_a : operand_b)};
      end
      CMD_MAX: begin
        sat = {1'b0, (s1_next.gt ? operand_a : operand_b)};
      end
      CMD_INC: begin
        sat = sat_signed(wide_a + WIDE_W'(1));
      end
      CMD_DEC: begin
        sat = sat_signed(wide_a - WIDE_W'(1));
      end
      CMD_TO_INT: begin
        sat = {1'b0, operand_a >>> FRAC_BITS};
      end
      CMD_FROM_INT: begin
        sat = sat_signed(wide_a << FRAC_BITS);
      end
      default: begin
        sat = '0;
      end
    endcase
    s1_next.ovf = sat[DATA_W];
    s1_next.res = sat[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
  end

  // Stage 2: round and saturate the product, seed the divider
  always_comb begin
    prod_rnd       = (s1.prod + (MAG_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    mul_sat        = sat_mag(prod_rnd, s1.neg);
    s2_next        = '0;
    s2_next.valid  = 1'b0;
    s2_next.is_div = s1.is_div;
    s2_next.neg    = s1.neg;
    s2_next.gt     = s1.gt;
    s2_next.lt     = s1.lt;
    s2_next.eq     = s1.eq;
    s2_next.dz     = s1.dz;
    s2_next.ovf    = s1.mul ? mul_sat[DATA_W] : s1.ovf;
    s2_next.res    = s1.mul ? mul_sat[DATA_W-1:0] : s1.res;
    s2_next.den    = s1.den;
    s2_next.num    = s1.num;
    s2_next.rem    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2 <= s2_next;
  end

  always_comb begin
    dout       = s2;
    dout.valid = s2_valid;
  end

endmodule

@@ rtl/fpa_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per item and hands
// the item to the next cell. Depends on fpa_pkg.
module fpa_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  fpa_pkg::cell_t din,
  output fpa_pkg::cell_t dout
);
  import fpa_pkg::*;

  logic [DATA_W:0] shifted;
  logic [DATA_W:0] diff;
  logic            take;
  cell_t           data_next;
  cell_t           data;
  logic            vld;

  // Shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    shifted        = {din.rem, din.num[NUM_W-1]};
    diff           = shifted - {1'b0, din.den};
    take           = shifted >= {1'b0, din.den};
    data_next      = din;
    data_next.rem  = take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    data_next.num  = {din.num[NUM_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  always_comb begin
    dout       = data;
    dout.valid = vld;
  end

endmodule

@@ rtl/fpa_back.sv @@
// Output stage: rounds and saturates the quotient, registers the result.
// Depends on fpa_pkg.
module fpa_back (
  input  logic                  clk,
  input  logic                  rst,
  input  fpa_pkg::cell_t        din,
  output logic                  done,
  output logic signed [31:0]    result,
  output logic                  a_greater,
  output logic                  a_less,
  output logic                  a_equal,
  output logic                  divide_by_zero,
  output logic                  overflow
);
  import fpa_pkg::*;

  logic             round_up;
  logic [MAG_W-1:0] q_rnd;
  logic [DATA_W:0]  div_sat;
  logic [DATA_W-1:0] res_next;
  logic             ovf_next;

  // Half away from zero: bump when twice the remainder reaches the divisor
  always_comb begin
    round_up = {din.rem, 1'b0} >= {1'b0, din.den};
    q_rnd    = MAG_W'(din.num) + MAG_W'(round_up);
    div_sat  = sat_mag(q_rnd, din.neg);
    res_next = din.is_div ? div_sat[DATA_W-1:0] : din.res;
    ovf_next = din.is_div ? div_sat[DATA_W] : din.ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    result         <= res_next;
    a_greater      <= din.gt;
    a_less         <= din.lt;
    a_equal        <= din.eq;
    divide_by_zero <= din.dz;
    overflow       <= ovf_next;
  end

endmodule

@@ rtl/fixed_point_q24_8_alu_top.sv @@
// Top level of the Q24.8 fixed-point ALU: front stages, divider cell chain,
// output stage. Depends on fpa_pkg, fpa_front, fpa_div_cell, fpa_back.
//
//  channel | handshake       | payload
//  --------+-----------------+-------------------------------------------------
//  input   | start, busy     | command, operand_a, operand_b
//  result  | done (strobe)   | result, a_greater, a_less, a_equal,
//          |                 | divide_by_zero, overflow
//
// One item is accepted every cycle; busy stays low.
// Every command passes the same path: two input stages, the divider chain with
// one cell per quotient bit, then one output stage.
// Results leave in order, one done pulse each; the receiver cannot stall.
// Synchronous reset clears the valid bits of all stages; items in flight are dropped.
module fixed_point_q24_8_alu_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         command,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               done,
  output logic signed [31:0] result,
  output logic               a_greater,
  output logic               a_less,
  output logic               a_equal,
  output logic               divide_by_zero,
  output logic               overflow
);
  import fpa_pkg::*;

  cell_t chain [0:NUM_W];

  assign busy = 1'b0;

  fpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (start && !busy),
    .command   (command),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .dout      (chain[0])
  );

  // Divider chain: one quotient bit per cell, MSB first
  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  fpa_back u_back (
    .clk            (clk),
    .rst            (rst),
    .din            (chain[NUM_W]),
    .done           (done),
    .result         (result),
    .a_greater      (a_greater),
    .a_less         (a_less),
    .a_equal        (a_equal),
    .divide_by_zero (divide_by_zero),
    .overflow       (overflow)
  );

endmodule

@@ rtl/fpa_checker.sv @@
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg and fixed_point_q24_8_alu_top_defines.svh.
`include "fixed_point_q24_8_alu_top_defines.svh"

module fpa_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] result,
  input logic               a_greater,
  input logic               a_less,
  input logic               a_equal,
  input logic               divide_by_zero,
  input logic               overflow
);
  import fpa_pkg::*;

  // Every accepted item comes out after the fixed latency
  `FPA_ASSERT(a_latency, clk, rst, (start && !busy) |-> ##LATENCY done)
  // No result without an item accepted the same latency before
  `FPA_ASSERT(a_no_phantom, clk, rst, done |-> $past(start && !busy, LATENCY))
  // Exactly one comparison flag per result
  `FPA_ASSERT(a_flags, clk, rst, done |-> $onehot({a_greater, a_less, a_equal}))
  // A zero divisor always saturates
  `FPA_ASSERT_NEVER(a_dz_sat, clk, rst, done && divide_by_zero &&
    (!overflow || (result != RAW_MAX && result != RAW_MIN)))

endmodule

bind fixed_point_q24_8_alu_top fpa_checker u_fpa_checker (.*);
